### design/brf_pkg.sv
`default_nettype none

package brf_pkg;

    // Store geometry; the pointer widths follow from it, the fill width of the result word is set apart
    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned AW           = $clog2(DEPTH);
    localparam int unsigned PW           = AW + 1;
    localparam int unsigned FILL_W       = 11;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned OVR_W        = 32;
    localparam int unsigned MAX_READ_DEF = 64;
    localparam int unsigned OUTQ_DEPTH   = 4;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_FLUSH  = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       data_byte;
        logic             burst_last;
        logic [CNT_W-1:0] read_count;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [7:0]        out_byte;
        logic              run_last;
        logic              write_accepted;
        logic [FILL_W-1:0] fill_level;
        logic [OVR_W-1:0]  overrun_total;
    } t_out_word;

    // Byte store access: one write and one read port
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

    // Result under construction; a read byte joins it from the store as it leaves this stage
    typedef struct packed {
        logic              valid;
        logic              from_ram;
        logic [1:0]        kind;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill;
        logic [OVR_W-1:0]  ovr;
    } t_res_stage;

endpackage

`default_nettype wire

### design/brf_ram.sv
`default_nettype none

module brf_ram (
    input  logic              i_clk,
    input  brf_pkg::t_ram_req i_req,
    output logic [7:0]        o_q
);
    import brf_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    // Write staged bytes
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read, enabled by re
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

### design/brf_ctrl.sv
`default_nettype none

module brf_ctrl #(
    parameter int unsigned MAX_READ = brf_pkg::MAX_READ_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  brf_pkg::t_in_word   i_word,
    input  logic                i_room,
    output brf_pkg::t_ram_req   o_ram,
    output brf_pkg::t_res_stage o_stg
);
    import brf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state           r_state, n_state;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_staged, n_staged;
    logic             r_too_big, n_too_big;
    logic [OVR_W-1:0] r_ovr, n_ovr;
    logic [PW-1:0]    r_raddr, n_raddr;
    logic [CNT_W-1:0] r_left, n_left;
    t_res_stage       r_stg, n_stg;

    logic             w_accept;
    logic [PW-1:0]    w_fill;
    logic [PW:0]      w_sum;
    logic             w_fits;
    logic             w_big_next;
    logic [PW-1:0]    w_staged_next;
    logic [CNT_W-1:0] w_cap;
    logic [CNT_W-1:0] w_n;
    logic [OVR_W-1:0] w_ovr_inc;

    assign o_stall  = (r_state != ST_IDLE) || !i_room;
    assign w_accept = i_valid && !o_stall;
    assign w_fill   = r_wp - r_rp;

    // Fit test against committed plus staged bytes
    assign w_sum         = {1'b0, w_fill} + {1'b0, r_staged};
    assign w_fits        = !r_too_big && (w_sum < (PW + 1)'(DEPTH));
    assign w_big_next    = r_too_big || !w_fits;
    assign w_staged_next = r_staged + PW'(w_fits);
    assign w_ovr_inc     = (r_ovr == '1) ? r_ovr : r_ovr + OVR_W'(1);

    // Clamp the read length to the limit and to the fill level
    assign w_cap = (i_word.read_count > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                          : i_word.read_count;
    assign w_n   = (PW'(w_cap) > w_fill) ? w_fill[CNT_W-1:0] : w_cap;

    // Staged writes land past the committed write pointer and reads only reach
    // committed bytes, so read and write never meet on one entry.
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_staged  = r_staged;
        n_too_big = r_too_big;
        n_ovr     = r_ovr;
        n_raddr   = r_raddr;
        n_left    = r_left;
        n_stg     = '0;
        o_ram       = '0;
        o_ram.waddr = AW'(r_wp + r_staged);
        o_ram.wdata = i_word.data_byte;
        o_ram.raddr = r_raddr[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_word.operation)
                        OP_WRITE: begin
                            o_ram.we = w_fits;
                            if (i_word.burst_last) begin
                                // Close the burst: commit or count an overrun
                                n_stg.valid = 1'b1;
                                n_stg.kind  = KIND_STATUS;
                                n_stg.last  = 1'b1;
                                if (w_big_next) begin
                                    n_ovr = w_ovr_inc;
                                end else begin
                                    n_wp           = r_wp + w_staged_next;
                                    n_stg.accepted = 1'b1;
                                end
                                n_staged  = '0;
                                n_too_big = 1'b0;
                            end else begin
                                n_staged  = w_staged_next;
                                n_too_big = w_big_next;
                            end
                        end
                        OP_READ: begin
                            if (w_n == '0) begin
                                n_stg.valid = 1'b1;
                                n_stg.kind  = KIND_EMPTY;
                                n_stg.last  = 1'b1;
                            end else begin
                                n_rp    = r_rp + PW'(w_n);
                                n_raddr = r_rp;
                                n_left  = w_n;
                                n_state = ST_RUN;
                            end
                        end
                        OP_FLUSH: begin
                            // Drop committed data, keep any open burst
                            n_rp        = r_wp;
                            n_stg.valid = 1'b1;
                            n_stg.kind  = KIND_FLUSH;
                            n_stg.last  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // Issue one store read per cycle while the queue has room
                if (i_room) begin
                    o_ram.re       = 1'b1;
                    n_stg.valid    = 1'b1;
                    n_stg.from_ram = 1'b1;
                    n_stg.kind     = KIND_BYTE;
                    n_stg.last     = (r_left == CNT_W'(1));
                    n_raddr        = r_raddr + PW'(1);
                    n_left         = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_stg.fill = FILL_W'(n_wp - n_rp);
        n_stg.ovr  = n_ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_staged  <= '0;
            r_too_big <= 1'b0;
            r_ovr     <= '0;
            r_left    <= '0;
            r_stg     <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_staged  <= n_staged;
            r_too_big <= n_too_big;
            r_ovr     <= n_ovr;
            r_left    <= n_left;
            r_stg     <= n_stg;
        end
        r_raddr <= n_raddr;
    end

    assign o_stg = r_stg;

endmodule

`default_nettype wire

### design/brf_outq.sv
`default_nettype none

module brf_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brf_pkg::t_res_stage i_stg,
    input  logic [7:0]          i_ram_q,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output brf_pkg::t_out_word  o_word
);
    import brf_pkg::*;

    localparam int unsigned QAW = $clog2(OUTQ_DEPTH);

    t_out_word      r_mem [OUTQ_DEPTH];
    logic [QAW-1:0] r_head, n_head;
    logic [QAW-1:0] r_tail, n_tail;
    logic [QAW:0]   r_count, n_count;

    t_out_word      w_push_word;
    logic           w_push;
    logic           w_pop;

    // Room counts the word still in the stage ahead of the queue
    assign o_room  = (r_count + (QAW + 1)'(i_stg.valid)) < (QAW + 1)'(OUTQ_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_head];

    assign w_push = i_stg.valid;
    assign w_pop  = o_valid && !i_stall;

    // Join the store byte with the staged result fields
    always_comb begin
        w_push_word.result_kind    = i_stg.kind;
        w_push_word.out_byte       = i_stg.from_ram ? i_ram_q : 8'h00;
        w_push_word.run_last       = i_stg.last;
        w_push_word.write_accepted = i_stg.accepted;
        w_push_word.fill_level     = i_stg.fill;
        w_push_word.overrun_total  = i_stg.ovr;
    end

    always_comb begin
        n_head  = w_pop  ? r_head + QAW'(1) : r_head;
        n_tail  = w_push ? r_tail + QAW'(1) : r_tail;
        n_count = r_count + (QAW + 1)'(w_push) - (QAW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Hold result words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= w_push_word;
        end
    end

endmodule

`default_nettype wire

### design/byte_ring_fifo_with_overrun.sv
// Write and flush items are taken one per cycle while the output queue has room; a read
// of n bytes stalls the input until it has issued its n store reads, one per cycle while
// the queue has room. A status, empty or flush result passes the result stage, then the
// output queue; a read byte passes the store's registered read beside the result stage.
// Synchronous active-low reset clears pointers, burst state, overrun count and the
// output queue; the byte store is not cleared.
`default_nettype none

module byte_ring_fifo_with_overrun #(
    parameter int unsigned MAX_READ = brf_pkg::MAX_READ_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  brf_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output brf_pkg::t_out_word o_word
);
    import brf_pkg::*;

    t_ram_req   w_ram;
    t_res_stage w_stg;
    logic [7:0] w_ram_q;
    logic       w_room;

    brf_ctrl #(
        .MAX_READ (MAX_READ)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .i_room  (w_room),
        .o_ram   (w_ram),
        .o_stg   (w_stg)
    );

    brf_ram u_ram (
        .i_clk (i_clk),
        .i_req (w_ram),
        .o_q   (w_ram_q)
    );

    brf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stg   (w_stg),
        .i_ram_q (w_ram_q),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

### design/brf_checker.sv
`default_nettype none

module brf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input brf_pkg::t_in_word  i_word,
    input logic               o_valid,
    input logic               i_stall,
    input brf_pkg::t_out_word o_word
);
    import brf_pkg::*;

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("result word changed while stalled");

    // Reset empties the output queue
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // Single-result kinds always close their run
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.result_kind != KIND_BYTE) |-> o_word.run_last)
        else $error("single result without last marker");

    // A flush leaves nothing committed
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.result_kind == KIND_FLUSH) |-> (o_word.fill_level == '0))
        else $error("fill level not zero after flush");

    // No byte on anything but a read byte; fill never beyond the store
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.fill_level <= FILL_W'(DEPTH)) &&
                    ((o_word.result_kind == KIND_BYTE) || (o_word.out_byte == 8'h00)))
        else $error("result fields out of range");

endmodule

bind byte_ring_fifo_with_overrun brf_checker u_brf_checker (.*);

`default_nettype wire
